>>> rtl/affs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package affs_pkg;

  // slot table geometry
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MEM_DEPTH  = SLOT_COUNT * 9;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);

  // fixed point constants, Q16.16
  localparam logic signed [31:0] FX_ONE     = 32'sd65536;
  localparam int                 TWO_PI_FX  = 411775;
  localparam int                 PI_FX      = 205887;
  localparam int                 HALF_PI_FX = 102944;

  // cordic constants, Q2.30
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_GAIN  = 652032874;

  localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1
  };

  typedef struct packed {
    logic [3:0]         slot;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] angle;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
  } item_t;

  typedef struct packed {
    logic               matrix_kind;
    logic [1:0]         row_index;
    logic signed [31:0] elem_col0;
    logic signed [31:0] elem_col1;
    logic signed [31:0] elem_col2;
    logic               last_row;
  } result_t;

  // one matrix row, element 0 in the low word
  typedef logic [2:0][31:0] row_t;

endpackage

`default_nettype wire

>>> rtl/affine_transform_stack_composer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// one item at a time; item_stall holds the next item off until the last composed
// row is issued, and result stalls hold the row emits; angle reduction and cordic
// come first, then matrix products of 27 single-multiplier steps, each with a drain
// six results per item: the new slot rows first, then the composed rows
// synchronous reset: slot table reads as identity, highest slot mark zero

module affine_transform_stack_composer_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire affs_pkg::item_t item,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output affs_pkg::result_t    result
);
  import affs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TRIG   = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_DRAIN  = 7'b0001000,
    S_EMIT_M = 7'b0010000,
    S_STORE  = 7'b0100000,
    S_EMIT_P = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    SRC_ROT  = 2'd0,
    SRC_TRN  = 2'd1,
    SRC_SLOT = 2'd2
  } src_t;

  state_t              state;
  src_t                src;
  item_t               item_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SLOT_W-1:0]   highest;
  logic [SLOT_W-1:0]   cur_slot;
  logic [SLOT_COUNT-1:0] slot_ok;

  row_t a_mat [3];
  row_t p_mat [3];

  logic [1:0] ci, cj, ck;
  logic [1:0] er;
  logic [1:0] sr, sc;

  // stage registers of the product pipeline
  logic               v1, v2;
  logic [1:0]         i1, j1, k1, i2, j2, k2;
  logic signed [31:0] a1;
  logic signed [31:0] bc1;
  logic               use_mem1;
  logic signed [63:0] prod;
  logic signed [49:0] acc;

  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] mem_q;

  logic               cor_done;
  logic signed [31:0] sin_v, cos_v;

  function automatic logic [MEM_AW-1:0] mem_addr(input logic [SLOT_W-1:0] s,
                                                 input logic [1:0] r,
                                                 input logic [1:0] c);
    mem_addr = MEM_AW'(s) * MEM_AW'(9) + MEM_AW'(r) * MEM_AW'(3) + MEM_AW'(c);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic row_t ident_row(input logic [1:0] r);
    row_t t;
    t = '0;
    t[r] = FX_ONE;
    ident_row = t;
  endfunction

  // right-hand operand element (k, j) of the non-memory matrices
  function automatic logic signed [31:0] b_elem(input src_t s, input logic [1:0] k,
                                                input logic [1:0] j,
                                                input logic signed [31:0] sn,
                                                input logic signed [31:0] cs,
                                                input logic signed [31:0] tx,
                                                input logic signed [31:0] ty);
    logic signed [31:0] v;
    v = (k == j) ? FX_ONE : 32'sd0;
    if (s == SRC_ROT) begin
      if ((k == 2'd0 && j == 2'd0) || (k == 2'd1 && j == 2'd1)) begin
        v = cs;
      end else if (k == 2'd0 && j == 2'd1) begin
        v = (sn == 32'sh80000000) ? 32'sh7fffffff : -sn;
      end else if (k == 2'd1 && j == 2'd0) begin
        v = sn;
      end
    end else if (s == SRC_TRN) begin
      if (k == 2'd0 && j == 2'd2) begin
        v = tx;
      end else if (k == 2'd1 && j == 2'd2) begin
        v = ty;
      end
    end
    b_elem = v;
  endfunction

  affs_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_IDLE && item_valid),
    .angle   (item.angle),
    .done    (cor_done),
    .sin_val (sin_v),
    .cos_val (cos_v)
  );

  assign item_stall = (state != S_IDLE);

  // slot table port: stores only in S_STORE, reads every cycle, the read used only by products issued in S_MUL
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa;
  logic [MEM_AW-1:0] mem_ra;
  assign mem_we = (state == S_STORE);
  assign mem_wa = mem_addr(slot_q, sr, sc);
  assign mem_ra = mem_addr(cur_slot, ck, cj);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= a_mat[sr][sc];
    end
    mem_q <= mem[mem_ra];
  end

  // multiply and accumulate stage
  logic signed [31:0] b1;
  logic signed [63:0] prod_c;
  logic signed [63:0] ps;
  logic signed [49:0] sum;
  assign b1     = use_mem1 ? $signed(mem_q) : bc1;
  assign prod_c = a1 * b1;
  assign ps     = prod >>> 16;
  assign sum    = ((k2 == 2'd0) ? 50'sd0 : acc) + ps[49:0];

  logic out_free;
  logic emit_go;
  logic last_issue;
  assign out_free   = !result_valid || !result_stall;
  assign emit_go    = (state == S_EMIT_M || state == S_EMIT_P) && out_free;
  assign last_issue = (ci == 2'd2) && (cj == 2'd2) && (ck == 2'd2);

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == S_MUL);
      v2 <= v1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    i1       <= ci;
    j1       <= cj;
    k1       <= ck;
    a1       <= $signed(a_mat[ci][ck]);
    bc1      <= b_elem(src, ck, cj, sin_v, cos_v, item_q.shift_x, item_q.shift_y);
    use_mem1 <= (src == SRC_SLOT) && slot_ok[cur_slot];
    i2       <= i1;
    j2       <= j1;
    k2       <= k1;
    prod     <= prod_c;
    if (v2) begin
      acc <= sum;
      if (k2 == 2'd2) begin
        p_mat[i2][j2] <= sat32(sum);
      end
    end
    if (state == S_IDLE) begin
      item_q <= item;
      slot_q <= (32'(item.slot) >= SLOT_COUNT) ? SLOT_W'(SLOT_COUNT - 1) : SLOT_W'(item.slot);
    end
    if (state == S_TRIG) begin
      a_mat[0] <= {32'd0, 32'd0, item_q.scale_x};
      a_mat[1] <= {32'd0, item_q.scale_y, 32'd0};
      a_mat[2] <= ident_row(2'd2);
    end else if (state == S_DRAIN && !v1 && !v2) begin
      a_mat <= p_mat;
    end else if (state == S_STORE && sr == 2'd2 && sc == 2'd2) begin
      a_mat[0] <= ident_row(2'd0);
      a_mat[1] <= ident_row(2'd1);
      a_mat[2] <= ident_row(2'd2);
    end
    if (emit_go) begin
      result.matrix_kind <= (state == S_EMIT_P);
      result.row_index   <= er;
      result.elem_col0   <= $signed(a_mat[er][0]);
      result.elem_col1   <= $signed(a_mat[er][1]);
      result.elem_col2   <= $signed(a_mat[er][2]);
      result.last_row    <= (state == S_EMIT_P) && (er == 2'd2);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      src          <= SRC_ROT;
      highest      <= '0;
      cur_slot     <= '0;
      slot_ok      <= '0;
      ci           <= '0;
      cj           <= '0;
      ck           <= '0;
      er           <= '0;
      sr           <= '0;
      sc           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_TRIG;
          end
        end
        S_TRIG: begin
          if (cor_done) begin
            src   <= SRC_ROT;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (last_issue) begin
            ci    <= '0;
            cj    <= '0;
            ck    <= '0;
            state <= S_DRAIN;
          end else if (ck == 2'd2) begin
            ck <= '0;
            if (cj == 2'd2) begin
              cj <= '0;
              ci <= ci + 2'd1;
            end else begin
              cj <= cj + 2'd1;
            end
          end else begin
            ck <= ck + 2'd1;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            er <= '0;
            case (src)
              SRC_ROT: begin
                src   <= SRC_TRN;
                state <= S_MUL;
              end
              SRC_TRN: begin
                state <= S_EMIT_M;
              end
              default: begin
                if (cur_slot == highest) begin
                  state <= S_EMIT_P;
                end else begin
                  cur_slot <= cur_slot + SLOT_W'(1);
                  state    <= S_MUL;
                end
              end
            endcase
          end
        end
        S_EMIT_M: begin
          if (out_free) begin
            er <= er + 2'd1;
            if (er == 2'd2) begin
              sr    <= '0;
              sc    <= '0;
              state <= S_STORE;
            end
          end
        end
        S_STORE: begin
          if (sc == 2'd2) begin
            sc <= '0;
            if (sr == 2'd2) begin
              sr               <= '0;
              slot_ok[slot_q]  <= 1'b1;
              highest          <= (slot_q > highest) ? slot_q : highest;
              cur_slot         <= '0;
              src              <= SRC_SLOT;
              state            <= S_MUL;
            end else begin
              sr <= sr + 2'd1;
            end
          end else begin
            sc <= sc + 2'd1;
          end
        end
        S_EMIT_P: begin
          if (out_free) begin
            if (er == 2'd2) begin
              er    <= '0;
              state <= S_IDLE;
            end else begin
              er <= er + 2'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // last transfer of a run is row two of the composed matrix
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_row |-> result.matrix_kind && result.row_index == 2'd2)
    else $error("last_row on a result that is not the final composed row");

  // accumulate stage is only fed from the multiply stage
  a_pipe: assert property (@(posedge clk) disable iff (rst) v2 |-> $past(v1))
    else $error("product stage valid without a preceding issue");

  // the highest slot mark never falls
  a_highest: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> highest >= $past(highest))
    else $error("highest slot mark decreased");

  // no product in flight while the table is written
  a_store_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_STORE |-> !v1 && !v2)
    else $error("slot store overlaps a matrix product");

endmodule

`default_nettype wire

>>> rtl/affs_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module affs_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] angle,
  output logic                    done,
  output logic signed [31:0]      sin_val,
  output logic signed [31:0]      cos_val
);
  import affs_pkg::*;

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_RED  = 5'b00010,
    C_FOLD = 5'b00100,
    C_ROT  = 5'b01000,
    C_OUT  = 5'b10000
  } cstate_t;

  cstate_t            state;
  logic [31:0]        rem;
  logic               neg;
  logic               flip;
  logic [4:0]         step;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;

  // restoring reduction by two pi times a power of two
  logic [33:0] red_sub;
  assign red_sub = {2'b00, rem} - (34'(TWO_PI_FX) << step[3:0]);

  // signed remainder moved into (-pi, pi] and folded into [-pi/2, pi/2]
  logic signed [20:0] r0;
  logic signed [20:0] r1;
  logic signed [20:0] r2;
  logic signed [20:0] r3;
  logic               fold;
  always_comb begin
    r0   = neg ? -$signed({2'b00, rem[18:0]}) : $signed({2'b00, rem[18:0]});
    r1   = (r0 < 0) ? r0 + 21'(TWO_PI_FX) : r0;
    r2   = (r1 > 21'(PI_FX)) ? r1 - 21'(TWO_PI_FX) : r1;
    fold = 1'b0;
    r3   = r2;
    if (r2 > 21'(HALF_PI_FX)) begin
      r3   = r2 - 21'(PI_FX);
      fold = 1'b1;
    end else if (r2 < -21'(HALF_PI_FX)) begin
      r3   = r2 + 21'(PI_FX);
      fold = 1'b1;
    end
  end

  // one rotation step
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  logic signed [33:0] xo;
  logic signed [33:0] yo;
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = $signed({4'b0000, ATAN_Q30[step]});
  assign xo = x >>> 14;
  assign yo = y >>> 14;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == C_OUT);
      case (state)
        C_IDLE: begin
          if (start) begin
            rem   <= angle[31] ? (~angle + 32'd1) : angle;
            neg   <= angle[31];
            step  <= 5'd13;
            state <= C_RED;
          end
        end
        C_RED: begin
          if (!red_sub[33]) begin
            rem <= red_sub[31:0];
          end
          if (step == 5'd0) begin
            state <= C_FOLD;
          end else begin
            step <= step - 5'd1;
          end
        end
        C_FOLD: begin
          flip  <= fold;
          z     <= {{13{r3[20]}}, r3} <<< 14;
          x     <= 34'(CORDIC_GAIN);
          y     <= '0;
          step  <= '0;
          state <= C_ROT;
        end
        C_ROT: begin
          if (!z[33]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          if (step == 5'(CORDIC_STEPS - 1)) begin
            state <= C_OUT;
          end else begin
            step <= step + 5'd1;
          end
        end
        C_OUT: begin
          cos_val <= 32'(flip ? -xo : xo);
          sin_val <= 32'(flip ? -yo : yo);
          state   <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> verif/affs_checker.sv
`timescale 1ns / 1ps

module affs_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire logic              item_stall,
  input  wire affs_pkg::item_t   item,
  input  wire logic              result_valid,
  input  wire logic              result_stall,
  input  wire affs_pkg::result_t result,
  output int                     fail_count,
  output int                     rows_pending
);
  import affs_pkg::*;

  typedef logic signed [31:0] mat_t [3][3];

  // angle steps of the cordic, q2.30
  localparam longint ATAN_TAB [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1
  };

  mat_t    slot_mats [SLOT_COUNT];
  int      top_slot;
  result_t expected_rows [$];

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void set_identity(output mat_t m);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = (i == j) ? 32'sd65536 : 32'sd0;
  endfunction

  function automatic void mat_product(input mat_t a, input mat_t b, output mat_t r);
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += (longint'(a[i][k]) * longint'(b[k][j])) >>> 16;
        r[i][j] = clamp32(acc);
      end
  endfunction

  // reduce angle, fold into half-pi range, then rotate
  function automatic void sine_cosine(input logic signed [31:0] ang,
                                      output logic signed [31:0] s,
                                      output logic signed [31:0] c);
    longint r, x, y, z, xs, ys;
    bit flip;
    r = longint'(ang) % 411775;
    flip = 0;
    x = 652032874;
    y = 0;
    if (r < 0) r += 411775;
    if (r > 205887) r -= 411775;
    if (r > 102944) begin
      r -= 205887;
      flip = 1;
    end else if (r < -102944) begin
      r += 205887;
      flip = 1;
    end
    z = r * 16384;
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end else begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end
    end
    x = x >>> 14;
    y = y >>> 14;
    if (flip) begin
      x = -x; y = -y;
    end
    c = clamp32(x);
    s = clamp32(y);
  endfunction

  function automatic void queue_rows(bit kind, mat_t m);
    result_t r;
    for (int k = 0; k < 3; k++) begin
      r.matrix_kind = kind;
      r.row_index   = k[1:0];
      r.elem_col0   = m[k][0];
      r.elem_col1   = m[k][1];
      r.elem_col2   = m[k][2];
      r.last_row    = kind && (k == 2);
      expected_rows.push_back(r);
    end
  endfunction

  // build the new slot matrix and the composed stack
  function automatic void compose_transfer(item_t it);
    mat_t scl, rot, trn, m, p, t;
    logic signed [31:0] s, c;
    int sl;
    sl = (it.slot >= SLOT_COUNT) ? SLOT_COUNT - 1 : it.slot;
    sine_cosine(it.angle, s, c);
    set_identity(scl); scl[0][0] = it.scale_x; scl[1][1] = it.scale_y;
    set_identity(rot);
    rot[0][0] = c; rot[0][1] = clamp32(-longint'(s));
    rot[1][0] = s; rot[1][1] = c;
    set_identity(trn); trn[0][2] = it.shift_x; trn[1][2] = it.shift_y;
    mat_product(scl, rot, t);
    mat_product(t, trn, m);
    if (sl > top_slot) top_slot = sl;
    slot_mats[sl] = m;
    set_identity(p);
    for (int i = 0; i <= top_slot; i++) begin
      mat_product(p, slot_mats[i], t);
      p = t;
    end
    queue_rows(0, m);
    queue_rows(1, p);
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  assign rows_pending = expected_rows.size();

  // watch both channels
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) set_identity(slot_mats[i]);
      top_slot = 0;
      expected_rows.delete();
    end else begin
      if (item_valid && !item_stall) compose_transfer(item);
      if (result_valid && !result_stall) begin
        if (expected_rows.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_rows.pop_front();
          if (result !== want)
            report_mismatch($sformatf("got %h expected %h", result, want));
        end
      end
    end
  end

  initial fail_count = 0;

  final begin
  end
endmodule

>>> verif/tb_affine_transform_stack_composer_unit.sv
`timescale 1ns / 1ps

module tb_affine_transform_stack_composer_unit;
  import affs_pkg::*;

  logic    clk = 0;
  logic    rst = 1;
  logic    item_valid = 0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 0;
  result_t result;
  int      fail_count;
  int      rows_pending;
  int      send_gap_pct = 12;
  int      recv_gap_pct = 77;
  bit      hold_recv = 0;

  affine_transform_stack_composer_unit dut (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid,
    .result_stall, .result
  );

  affs_checker chk (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid,
    .result_stall, .result, .fail_count, .rows_pending
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00010000 * $urandom_range(0, 4) - 32'h00020000;
      3: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
      default: return $urandom;
    endcase
  endfunction

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_recv) result_stall <= 1;
    else result_stall <= ($urandom_range(0, 99) < recv_gap_pct);
  end

  // valid stays high between back-to-back transfers
  task automatic send_transfer(item_t it);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic send_fields(int sl, logic [31:0] sx, logic [31:0] sy,
                             logic [31:0] an, logic [31:0] tx, logic [31:0] ty);
    item_t it;
    it.slot = 4'(sl); it.scale_x = sx; it.scale_y = sy; it.angle = an;
    it.shift_x = tx; it.shift_y = ty;
    send_transfer(it);
  endtask

  task automatic send_random(int n, int max_slot);
    for (int i = 0; i < n; i++)
      send_fields($urandom_range(0, max_slot), pick_word(), pick_word(), pick_word(),
                  pick_word(), pick_word());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: identity-like, angle corners, field extremes, slot range
    send_fields(0, 32'h10000, 32'h10000, 0, 0, 0);
    send_fields(1, 32'h10000, 32'h10000, 32'd102944, 32'h10000, 32'hffff0000);
    send_fields(2, 32'h20000, 32'h8000, 32'd205887, 0, 0);
    send_fields(3, 32'h10000, 32'h10000, -32'sd102944, 0, 0);
    send_fields(4, 32'h10000, 32'h10000, 32'd411775, 0, 0);
    send_fields(5, 32'h10000, 32'h10000, -32'sd205887, 0, 0);
    send_fields(15, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_fields(15, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_fields(7, 32'hffffffff, 32'h00000001, 32'hffffffff, 32'hffffffff, 32'h1);
    send_fields(8, 32'h0, 32'h0, 32'd102945, 32'h0, 32'h0);
    send_fields(0, 32'h10000, 32'h10000, 32'd205888, 32'h7fffffff, 32'h7fffffff);
    send_fields(10, 32'h10000, 32'hffff0000, 32'd50000, 32'h12345678, 32'h9abcdef0);
    send_random(40, 15);
    // long receiver hold-off while items keep coming
    fork
      begin
        hold_recv = 1;
        repeat (3000) @(posedge clk);
        hold_recv = 0;
      end
      begin
        send_random(6, 15);
        item_valid <= 0;
        @(posedge clk);
      end
    join
    send_gap_pct = 77; recv_gap_pct = 12;
    send_random(40, 15);
    send_gap_pct = 0; recv_gap_pct = 0;
    send_random(35, 15);
    item_valid <= 0;
    while (rows_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("tb_affine_transform_stack_composer_unit passed");
    else $display("tb_affine_transform_stack_composer_unit failed");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb_affine_transform_stack_composer_unit failed");
    $finish;
  end
endmodule
